@@ sv/btpr_pkg.sv @@
package btpr_pkg;

    localparam int PRIME_BITS = 16;
    localparam int WIDE_BITS  = 2 * PRIME_BITS;
    localparam int DIV_CNT_W  = $clog2(WIDE_BITS + 1);

    // Residues mod 8 for which 2 can be a primitive root.
    localparam logic [2:0] RESIDUE_A = 3'd3;
    localparam logic [2:0] RESIDUE_B = 3'd5;

    localparam logic [PRIME_BITS-1:0] VAL_ONE = PRIME_BITS'(1);
    localparam logic [PRIME_BITS-1:0] VAL_TWO = PRIME_BITS'(2);
    localparam logic [PRIME_BITS-1:0] VAL_THREE = PRIME_BITS'(3);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_POW_HALF,
        OP_STRIP2,
        OP_SET_D3,
        OP_DIV_ND,
        OP_DIV_PM1_D,
        OP_DIV_PM1_N,
        OP_POW_Q,
        OP_N_QUOT,
        OP_D_INC,
        OP_MUL_ACC,
        OP_MUL_B,
        OP_DIV_PROD,
        OP_ACC_REM,
        OP_B_REM_SHIFT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic emit;
        logic emit_val;
    } cmd_t;

    typedef struct packed {
        logic is_two;
        logic residue_ok;
        logic n_even;
        logic n_is_one;
        logic n_gt_one;
        logic d_sq_le;
        logic div_done;
        logic rem_zero;
        logic e_zero;
        logic e_lsb;
        logic acc_one;
        logic out_free;
    } status_t;

    typedef enum logic [1:0] {
        CTX_TWO,
        CTX_D,
        CTX_LAST
    } ctx_t;

endpackage

@@ sv/btpr_cand_if.sv @@
interface btpr_cand_if;
    logic                             valid;
    logic                             ready;
    logic [btpr_pkg::PRIME_BITS-1:0]  candidate;

    modport source (output valid, output candidate, input ready);
    modport sink (input valid, input candidate, output ready);
endinterface

@@ sv/btpr_res_if.sv @@
interface btpr_res_if;
    logic valid;
    logic ready;
    logic is_generator;

    modport source (output valid, output is_generator, input ready);
    modport sink (input valid, input is_generator, output ready);
endinterface

@@ sv/base_two_primitive_root_test.sv @@
// When the residue mod 8 settles the answer, the controller goes from the load straight
// to emit; otherwise each trial divisor takes one divider run and each exponent bit of
// each modular power takes up to two products, each reduced by the shared bit-serial
// divider, which sets the time a word takes.
// Throughput: one word at a time; the next word is taken as soon as the result
// sits in the output register. Reset clears the controller, divider and output valid.
module base_two_primitive_root_test (
    input  logic         clk,
    input  logic         rst_n,
    btpr_cand_if.sink    cand,
    btpr_res_if.source   res
);

    btpr_pkg::cmd_t     cmd;
    btpr_pkg::status_t  status;
    logic               in_ready;

    btpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cand.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    btpr_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .candidate    (cand.candidate),
        .res_valid    (res.valid),
        .res_ready    (res.ready),
        .is_generator (res.is_generator)
    );

    assign cand.ready = in_ready;

endmodule

@@ sv/btpr_divider.sv @@
// Restoring divider, one quotient bit per cycle. A narrow request divides a
// PRIME_BITS dividend, a wide one a double-width dividend.
module btpr_divider (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               wide,
    input  logic [btpr_pkg::WIDE_BITS-1:0]     dividend,
    input  logic [btpr_pkg::PRIME_BITS-1:0]    divisor,
    output logic                               done,
    output logic [btpr_pkg::PRIME_BITS-1:0]    quot,
    output logic [btpr_pkg::PRIME_BITS-1:0]    rem
);

    localparam int W  = btpr_pkg::PRIME_BITS;
    localparam int WW = btpr_pkg::WIDE_BITS;
    localparam int CW = btpr_pkg::DIV_CNT_W;

    logic [WW-1:0] dq_reg, dq_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;

    assign trial = {rem_reg, dq_reg[WW-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dq_next   = wide ? dividend : {dividend[W-1:0], {W{1'b0}}};
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = wide ? CW'(WW) : CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dq_next  = {dq_reg[WW-2:0], ge};
            rem_next = ge ? diff[W-1:0] : trial[W-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign quot = dq_reg[W-1:0];
    assign rem  = rem_reg;

endmodule

@@ sv/btpr_datapath.sv @@
module btpr_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  btpr_pkg::cmd_t                     cmd,
    output btpr_pkg::status_t                  status,
    input  logic [btpr_pkg::PRIME_BITS-1:0]    candidate,
    output logic                               res_valid,
    input  logic                               res_ready,
    output logic                               is_generator
);

    localparam int W  = btpr_pkg::PRIME_BITS;
    localparam int WW = btpr_pkg::WIDE_BITS;

    logic [W-1:0]  p_reg, p_next;
    logic [W-1:0]  pm1_reg, pm1_next;
    logic [W-1:0]  n_reg, n_next;
    logic [W-1:0]  d_reg, d_next;
    logic [W-1:0]  e_reg, e_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  b_reg, b_next;
    logic [WW-1:0] prod_reg, prod_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_val_reg, out_val_next;

    logic          div_start;
    logic          div_wide;
    logic [WW-1:0] div_dividend;
    logic [W-1:0]  div_divisor;
    logic          div_done;
    logic [W-1:0]  div_quot;
    logic [W-1:0]  div_rem;
    logic [WW-1:0] d_sq;

    btpr_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .wide     (div_wide),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_comb
    begin
        div_start    = 1'b0;
        div_wide     = 1'b0;
        div_dividend = {{W{1'b0}}, n_reg};
        div_divisor  = d_reg;
        case (cmd.op)
            btpr_pkg::OP_DIV_ND:
            begin
                div_start = 1'b1;
            end
            btpr_pkg::OP_DIV_PM1_D:
            begin
                div_start    = 1'b1;
                div_dividend = {{W{1'b0}}, pm1_reg};
            end
            btpr_pkg::OP_DIV_PM1_N:
            begin
                div_start    = 1'b1;
                div_dividend = {{W{1'b0}}, pm1_reg};
                div_divisor  = n_reg;
            end
            btpr_pkg::OP_DIV_PROD:
            begin
                div_start    = 1'b1;
                div_wide     = 1'b1;
                div_dividend = prod_reg;
                div_divisor  = p_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        p_next    = p_reg;
        pm1_next  = pm1_reg;
        n_next    = n_reg;
        d_next    = d_reg;
        e_next    = e_reg;
        acc_next  = acc_reg;
        b_next    = b_reg;
        prod_next = prod_reg;
        case (cmd.op)
            btpr_pkg::OP_LOAD:
            begin
                p_next   = candidate;
                pm1_next = candidate - btpr_pkg::VAL_ONE;
                n_next   = candidate - btpr_pkg::VAL_ONE;
            end
            btpr_pkg::OP_POW_HALF:
            begin
                e_next   = {1'b0, pm1_reg[W-1:1]};
                acc_next = btpr_pkg::VAL_ONE;
                b_next   = btpr_pkg::VAL_TWO;
            end
            btpr_pkg::OP_STRIP2:     n_next = {1'b0, n_reg[W-1:1]};
            btpr_pkg::OP_SET_D3:     d_next = btpr_pkg::VAL_THREE;
            btpr_pkg::OP_POW_Q:
            begin
                e_next   = div_quot;
                acc_next = btpr_pkg::VAL_ONE;
                b_next   = btpr_pkg::VAL_TWO;
            end
            btpr_pkg::OP_N_QUOT:     n_next = div_quot;
            btpr_pkg::OP_D_INC:      d_next = d_reg + btpr_pkg::VAL_TWO;
            btpr_pkg::OP_MUL_ACC:    prod_next = WW'(acc_reg) * WW'(b_reg);
            btpr_pkg::OP_MUL_B:      prod_next = WW'(b_reg) * WW'(b_reg);
            btpr_pkg::OP_ACC_REM:    acc_next = div_rem;
            btpr_pkg::OP_B_REM_SHIFT:
            begin
                b_next = div_rem;
                e_next = {1'b0, e_reg[W-1:1]};
            end
            default:
            begin
            end
        endcase
    end

    // The output word register lets the next candidate start while a result waits.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_val_next   = out_val_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_val_next   = cmd.emit_val;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg       <= p_next;
        pm1_reg     <= pm1_next;
        n_reg       <= n_next;
        d_reg       <= d_next;
        e_reg       <= e_next;
        acc_reg     <= acc_next;
        b_reg       <= b_next;
        prod_reg    <= prod_next;
        out_val_reg <= out_val_next;
    end

    assign d_sq = WW'(d_reg) * WW'(d_reg);

    always_comb
    begin
        status.is_two     = p_reg == btpr_pkg::VAL_TWO;
        status.residue_ok = (p_reg[2:0] == btpr_pkg::RESIDUE_A) ||
                            (p_reg[2:0] == btpr_pkg::RESIDUE_B);
        status.n_even     = !n_reg[0];
        status.n_is_one   = n_reg == btpr_pkg::VAL_ONE;
        status.n_gt_one   = n_reg > btpr_pkg::VAL_ONE;
        status.d_sq_le    = d_sq <= {{W{1'b0}}, pm1_reg};
        status.div_done   = div_done;
        status.rem_zero   = div_rem == '0;
        status.e_zero     = e_reg == '0;
        status.e_lsb      = e_reg[0];
        status.acc_one    = acc_reg == btpr_pkg::VAL_ONE;
        status.out_free   = !out_valid_reg || res_ready;
    end

    assign res_valid    = out_valid_reg;
    assign is_generator = out_val_reg;

endmodule

@@ sv/btpr_ctrl.sv @@
module btpr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  btpr_pkg::status_t  status,
    output btpr_pkg::cmd_t     cmd
);

    typedef enum logic [17:0] {
        S_IDLE     = 18'b000000000000000001,
        S_CLASSIFY = 18'b000000000000000010,
        S_STRIP2   = 18'b000000000000000100,
        S_LOOP     = 18'b000000000000001000,
        S_WND      = 18'b000000000000010000,
        S_DPM      = 18'b000000000000100000,
        S_WQ       = 18'b000000000001000000,
        S_PCHK     = 18'b000000000010000000,
        S_DACC     = 18'b000000000100000000,
        S_WACC     = 18'b000000001000000000,
        S_MB       = 18'b000000010000000000,
        S_DB       = 18'b000000100000000000,
        S_WB       = 18'b000001000000000000,
        S_PEND     = 18'b000010000000000000,
        S_SD       = 18'b000100000000000000,
        S_WSD      = 18'b001000000000000000,
        S_EMIT     = 18'b010000000000000000,
        S_SPARE    = 18'b100000000000000000
    } state_t;

    state_t            state_reg, state_next;
    btpr_pkg::ctx_t    ctx_reg, ctx_next;
    logic              res_reg, res_next;

    always_comb
    begin
        state_next   = state_reg;
        ctx_next     = ctx_reg;
        res_next     = res_reg;
        cmd.op       = btpr_pkg::OP_NONE;
        cmd.emit     = 1'b0;
        cmd.emit_val = res_reg;
        in_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = btpr_pkg::OP_LOAD;
                    state_next = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                if (status.is_two)
                begin
                    res_next   = 1'b1;
                    state_next = S_EMIT;
                end
                else if (!status.residue_ok)
                begin
                    res_next   = 1'b0;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.op     = btpr_pkg::OP_POW_HALF;
                    ctx_next   = btpr_pkg::CTX_TWO;
                    state_next = S_PCHK;
                end
            end
            S_STRIP2:
            begin
                if (status.n_even)
                begin
                    cmd.op = btpr_pkg::OP_STRIP2;
                end
                else
                begin
                    cmd.op     = btpr_pkg::OP_SET_D3;
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                // Once the cofactor is one, no further prime factor remains.
                if (status.n_is_one)
                begin
                    res_next   = 1'b1;
                    state_next = S_EMIT;
                end
                else if (!status.d_sq_le)
                begin
                    if (status.n_gt_one)
                    begin
                        cmd.op     = btpr_pkg::OP_DIV_PM1_N;
                        ctx_next   = btpr_pkg::CTX_LAST;
                        state_next = S_WQ;
                    end
                    else
                    begin
                        res_next   = 1'b1;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    cmd.op     = btpr_pkg::OP_DIV_ND;
                    state_next = S_WND;
                end
            end
            S_WND:
            begin
                if (status.div_done)
                begin
                    if (status.rem_zero)
                    begin
                        cmd.op     = btpr_pkg::OP_N_QUOT;
                        state_next = S_DPM;
                    end
                    else
                    begin
                        cmd.op     = btpr_pkg::OP_D_INC;
                        state_next = S_LOOP;
                    end
                end
            end
            S_DPM:
            begin
                cmd.op     = btpr_pkg::OP_DIV_PM1_D;
                ctx_next   = btpr_pkg::CTX_D;
                state_next = S_WQ;
            end
            S_WQ:
            begin
                if (status.div_done)
                begin
                    cmd.op     = btpr_pkg::OP_POW_Q;
                    state_next = S_PCHK;
                end
            end
            S_PCHK:
            begin
                if (status.e_zero)
                begin
                    state_next = S_PEND;
                end
                else if (status.e_lsb)
                begin
                    cmd.op     = btpr_pkg::OP_MUL_ACC;
                    state_next = S_DACC;
                end
                else
                begin
                    cmd.op     = btpr_pkg::OP_MUL_B;
                    state_next = S_DB;
                end
            end
            S_DACC:
            begin
                cmd.op     = btpr_pkg::OP_DIV_PROD;
                state_next = S_WACC;
            end
            S_WACC:
            begin
                if (status.div_done)
                begin
                    cmd.op     = btpr_pkg::OP_ACC_REM;
                    state_next = S_MB;
                end
            end
            S_MB:
            begin
                cmd.op     = btpr_pkg::OP_MUL_B;
                state_next = S_DB;
            end
            S_DB:
            begin
                cmd.op     = btpr_pkg::OP_DIV_PROD;
                state_next = S_WB;
            end
            S_WB:
            begin
                if (status.div_done)
                begin
                    cmd.op     = btpr_pkg::OP_B_REM_SHIFT;
                    state_next = S_PCHK;
                end
            end
            S_PEND:
            begin
                if (status.acc_one)
                begin
                    res_next   = 1'b0;
                    state_next = S_EMIT;
                end
                else
                begin
                    case (ctx_reg)
                        btpr_pkg::CTX_TWO:  state_next = S_STRIP2;
                        btpr_pkg::CTX_D:    state_next = S_SD;
                        default:
                        begin
                            res_next   = 1'b1;
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_SD:
            begin
                cmd.op     = btpr_pkg::OP_DIV_ND;
                state_next = S_WSD;
            end
            S_WSD:
            begin
                if (status.div_done)
                begin
                    if (status.rem_zero)
                    begin
                        cmd.op     = btpr_pkg::OP_N_QUOT;
                        state_next = S_SD;
                    end
                    else
                    begin
                        cmd.op     = btpr_pkg::OP_D_INC;
                        state_next = S_LOOP;
                    end
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ctx_reg   <= btpr_pkg::CTX_TWO;
            res_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
            res_reg   <= res_next;
        end
    end

endmodule

@@ verif/tb_base_two_primitive_root_test.sv @@
module tb_base_two_primitive_root_test;

    localparam int RANDOM_WORDS = 116;
    localparam int MAX_IDLE     = 17;
    localparam int DRAIN_CYCLES = 64;

    typedef logic [btpr_pkg::PRIME_BITS-1:0] cand_t;

    typedef struct {
        cand_t cand;
        bit    flag;
    } verdict_t;

    // Keeps the verdicts of accepted candidates in order and checks each result
    // word against the oldest one.
    class root_scoreboard;
        verdict_t pending_verdicts[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        // 2^e mod m with products held at 64 bits.
        static function longint unsigned pow_two_mod(longint unsigned e, longint unsigned m);
            longint unsigned acc;
            longint unsigned base;
            acc  = 1;
            base = 2 % m;
            while (e > 0)
            begin
                if ((e & 1) != 0)
                    acc = (acc * base) % m;
                e    = e >> 1;
                base = (base * base) % m;
            end
            return acc;
        endfunction

        static function bit two_is_generator(cand_t cand);
            longint unsigned p;
            longint unsigned pm1;
            longint unsigned n;
            longint unsigned d;
            p = cand;
            if (cand == btpr_pkg::VAL_TWO)
                return 1'b1;
            if (cand[2:0] != btpr_pkg::RESIDUE_A && cand[2:0] != btpr_pkg::RESIDUE_B)
                return 1'b0;
            pm1 = p - 1;
            n   = pm1;
            if ((n & 1) == 0)
            begin
                if (pow_two_mod(pm1 / 2, p) == 1)
                    return 1'b0;
                while (n != 0 && (n & 1) == 0)
                    n = n >> 1;
            end
            for (d = 3; d * d <= pm1; d += 2)
            begin
                if (n % d == 0)
                begin
                    if (pow_two_mod(pm1 / d, p) == 1)
                        return 1'b0;
                    while (n != 0 && n % d == 0)
                        n = n / d;
                end
            end
            // A cofactor left above one is the last prime factor.
            if (n > 1 && pow_two_mod(pm1 / n, p) == 1)
                return 1'b0;
            return 1'b1;
        endfunction

        function void note_candidate(cand_t cand);
            verdict_t v;
            v.cand = cand;
            v.flag = two_is_generator(cand);
            pending_verdicts.push_back(v);
        endfunction

        function void check_result(logic flag);
            verdict_t v;
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: result word with none expected, expected none, actual %0b",
                         $time, flag);
                errors++;
            end
            else
            begin
                v = pending_verdicts.pop_front();
                if (flag !== v.flag)
                begin
                    $display("%0t: is_generator for candidate %0d, expected %0b, actual %0b",
                             $time, v.cand, v.flag, flag);
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    btpr_cand_if cand_bus ();
    btpr_res_if  res_bus ();

    base_two_primitive_root_test uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cand  (cand_bus),
        .res   (res_bus)
    );

    root_scoreboard board = new();
    int             words_sent = 0;
    int             results_seen = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly well-formed candidates: small values with residue 3 or 5, many of
    // them prime, so that the factoring and power loops run. A few use the full
    // width, and the rest is plain noise.
    function automatic cand_t pick_candidate();
        int    kind;
        int    k;
        bit    composite;
        cand_t v;
        kind = $urandom_range(0, 9);
        if (kind <= 6)
        begin
            forever
            begin
                v = {cand_t'($urandom_range(0, 127)) << 3};
                v[2:0] = ($urandom_range(0, 1) != 0) ? btpr_pkg::RESIDUE_A
                                                     : btpr_pkg::RESIDUE_B;
                composite = 1'b0;
                for (k = 3; k * k <= int'(v); k += 2)
                    if (int'(v) % k == 0)
                        composite = 1'b1;
                if (!composite || kind > 3)
                    break;
            end
        end
        else if (kind == 7)
        begin
            v = cand_t'($urandom());
            v[2:0] = ($urandom_range(0, 1) != 0) ? btpr_pkg::RESIDUE_A
                                                 : btpr_pkg::RESIDUE_B;
        end
        else
            v = cand_t'($urandom());
        return v;
    endfunction

    task automatic send_candidate(cand_t value);
        int gap;
        gap = ((words_sent / 24) % 3 == 2) ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            cand_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cand_bus.valid     <= 1'b1;
        cand_bus.candidate <= value;
        do
            @(posedge clk);
        while (cand_bus.ready !== 1'b1);
        board.note_candidate(value);
        words_sent++;
    endtask

    task automatic take_result();
        int stall;
        stall = ((results_seen / 20) % 3 == 1) ? 0 : $urandom_range(0, MAX_IDLE);
        if (stall > 0)
        begin
            res_bus.ready <= 1'b0;
            repeat (stall) @(posedge clk);
        end
        res_bus.ready <= 1'b1;
        do
            @(posedge clk);
        while (res_bus.valid !== 1'b1);
        board.check_result(res_bus.is_generator);
        results_seen++;
    endtask

    initial
    begin
        cand_t directed[$];
        int    i;
        directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd11,
                     16'd13, 16'd43, 16'd109, 16'd59, 16'd27, 16'd21, 16'd9,
                     16'd1021, 16'd32771, 16'h5555, 16'hAAAA, 16'd65535,
                     16'd65533, 16'd65531, 16'd65521, 16'd65491};
        rst_n              <= 1'b0;
        cand_bus.valid     <= 1'b0;
        cand_bus.candidate <= '0;
        res_bus.ready      <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[j])
            send_candidate(directed[j]);
        for (i = 0; i < RANDOM_WORDS; i++)
            send_candidate(pick_candidate());
        cand_bus.valid <= 1'b0;
        while (board.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        forever
            take_result();
    end

    initial
    begin
        #50000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
